>>> sv/bfiq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared constants and types of the bloom filter insert/query block.
// ----------------------------------------------------------------------------
package bfiq_pkg;

  localparam int unsigned MaxBytesDef    = 4096;
  localparam int unsigned NumProbesDef   = 16;
  localparam int unsigned CfgW           = 13;
  localparam int unsigned KeyW           = 32;
  localparam int unsigned HashW          = 64;
  localparam int unsigned DivBits        = 8;
  localparam int unsigned NumDigits      = 10;

  localparam logic [CfgW-1:0]  FilterBytesRst = 13'd4096;
  localparam logic [HashW-1:0] SeedA          = 64'd5381;
  localparam logic [31:0]      Recip10        = 32'hCCCCCCCD;
  localparam int unsigned      Recip10Shift   = 35;
  localparam logic [7:0]       CharMinus      = 8'd45;
  localparam logic [7:0]       CharZero       = 8'd48;

  typedef enum logic {
    ModeInsert = 1'b0,
    ModeQuery  = 1'b1
  } mode_e;

  // One hashed key on its way from the front to the back
  typedef struct packed {
    mode_e             mode;
    logic [HashW-1:0]  ha;
    logic [HashW-1:0]  hb;
  } job_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic probing;
  } back_stat_t;

endpackage
`default_nettype wire

>>> sv/bloom_filter_insert_query.sv
// Flow: the key is split into decimal digits and both hashes run over its text
// (a minus sign first, if any); each probe then reduces its address, reads the
// memory and tests or sets the bit; a query that meets a clear bit stops there.
// The probe unit limits the rate of keys; hashing of the next key overlaps
// through a two-entry queue.
// Reset: a clearing pass holds busy high; no result stalls.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter with double hashing over the decimal text of signed keys.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query #(
  parameter int unsigned MAX_BYTES  = bfiq_pkg::MaxBytesDef,
  parameter int unsigned NUM_PROBES = bfiq_pkg::NumProbesDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       mode_i,
  input  wire logic signed [31:0]         key_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [bfiq_pkg::CfgW-1:0]  cfg_wdata_i,
  output logic                            done_o,
  output logic                            maybe_present_o
);

  localparam int unsigned IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned SPAN_W = IDX_W + 4;

  logic [bfiq_pkg::CfgW-1:0] fb_q;
  logic [31:0]               used;
  logic [SPAN_W-1:0]         span;
  logic                      accept;
  logic                      front_busy;
  logic                      push, full, qvalid, pop;
  bfiq_pkg::job_t            push_job, pop_job;
  bfiq_pkg::back_stat_t      stat;

  // Hold the size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fb_q <= bfiq_pkg::FilterBytesRst;
    else if (cfg_we_i) fb_q <= cfg_wdata_i;
  end

  // Clamp size into range and form the bit span
  always_comb begin
    used = 32'(fb_q);
    if (used == 32'd0) used = 32'd1;
    if (used > MAX_BYTES) used = 32'(MAX_BYTES);
  end
  assign span = SPAN_W'(used << 3);

  assign busy   = front_busy || stat.clearing;
  assign accept = start && !busy;

  bfiq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (mode_i),
    .key_i    (key_i),
    .full_i   (full),
    .busy_o   (front_busy),
    .push_o   (push),
    .job_o    (push_job)
  );

  bfiq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (qvalid),
    .job_o   (pop_job)
  );

  bfiq_back #(
    .MAX_BYTES  (MAX_BYTES),
    .NUM_PROBES (NUM_PROBES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (qvalid),
    .job_i           (pop_job),
    .span_i          (span),
    .pop_o           (pop),
    .done_o          (done_o),
    .maybe_present_o (maybe_present_o),
    .stat_o          (stat)
  );

`ifndef ASSERT_OFF
  // A result follows only a probe test
  a_done_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(stat.probing))
    else $error("result without a probe test");

  // No result during the clearing pass
  a_no_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !done_o)
    else $error("result during clearing");

  // A transfer in makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after transfer");
`endif

endmodule
`default_nettype wire

>>> sv/bfiq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfiq_front
// Takes a key, splits it into decimal digits and forms both string hashes.
// ----------------------------------------------------------------------------
module bfiq_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic                        mode_i,
  input  wire logic signed [31:0]          key_i,
  input  wire logic                        full_i,
  output logic                             busy_o,
  output logic                             push_o,
  output bfiq_pkg::job_t                   job_o
);

  localparam logic [1:0] FIdle  = 2'd0;
  localparam logic [1:0] FDigit = 2'd1;
  localparam logic [1:0] FHash  = 2'd2;
  localparam logic [1:0] FPush  = 2'd3;

  logic [1:0]   state_q;
  logic [31:0]  mag_q;
  logic         neg_q;
  logic [3:0]   n_q;
  logic [3:0]   digit_q [bfiq_pkg::NumDigits];
  logic         mode_q;
  logic [63:0]  ha_q, hb_q;

  logic [63:0]  prod;
  logic [31:0]  quot;
  logic [3:0]   dig;
  logic [3:0]   top_ix;
  logic [7:0]   ch;
  logic [63:0]  ha_d, hb_d;

  // Divide by ten through the reciprocal
  assign prod = {32'd0, mag_q} * {32'd0, bfiq_pkg::Recip10};
  assign quot = {3'd0, prod[63:bfiq_pkg::Recip10Shift]};
  assign dig  = 4'(mag_q - ((quot << 3) + (quot << 1)));

  // Next character: sign first, then digits from the most significant
  assign top_ix = n_q - 4'd1;
  assign ch = neg_q ? bfiq_pkg::CharMinus : (bfiq_pkg::CharZero + {4'd0, digit_q[top_ix]});

  assign ha_d = (ha_q << 5) + ha_q + {56'd0, ch};
  assign hb_d = {56'd0, ch} + (hb_q << 6) + (hb_q << 16) - hb_q;

  // Sequence one key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      n_q     <= 4'd0;
      neg_q   <= 1'b0;
    end else begin
      unique case (state_q)
        FIdle: begin
          if (accept_i) begin
            neg_q   <= key_i[31];
            n_q     <= 4'd0;
            state_q <= FDigit;
          end
        end
        FDigit: begin
          n_q <= n_q + 4'd1;
          if (quot == 32'd0) state_q <= FHash;
        end
        FHash: begin
          if (neg_q) begin
            neg_q <= 1'b0;
          end else begin
            n_q <= top_ix;
            if (n_q == 4'd1) state_q <= FPush;
          end
        end
        FPush: begin
          if (!full_i) state_q <= FIdle;
        end
        default: state_q <= FIdle;
      endcase
    end
  end

  // Payload: magnitude, digits, hashes
  always_ff @(posedge clk_i) begin
    if (state_q == FIdle && accept_i) begin
      mag_q  <= key_i[31] ? (32'd0 - key_i) : key_i;
      mode_q <= mode_i;
      ha_q   <= bfiq_pkg::SeedA;
      hb_q   <= 64'd0;
    end
    if (state_q == FDigit) begin
      digit_q[n_q] <= dig;
      mag_q        <= quot;
    end
    if (state_q == FHash) begin
      ha_q <= ha_d;
      hb_q <= hb_d;
    end
  end

  assign busy_o     = (state_q != FIdle);
  assign push_o     = (state_q == FPush) && !full_i;
  assign job_o.mode = bfiq_pkg::mode_e'(mode_q);
  assign job_o.ha   = ha_q;
  assign job_o.hb   = hb_q;

endmodule
`default_nettype wire

>>> sv/bfiq_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfiq_queue
// Two-entry queue of hashed keys between the front and the back.
// ----------------------------------------------------------------------------
module bfiq_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bfiq_pkg::job_t  job_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output bfiq_pkg::job_t       job_o
);

  bfiq_pkg::job_t entry_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= job_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = entry_q[rd_q];

endmodule
`default_nettype wire

>>> sv/bfiq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfiq_back
// Runs the probes of one key: reduces each address, then reads and sets
// or tests its bit in the filter memory. Clears the memory after reset.
// ----------------------------------------------------------------------------
module bfiq_back #(
  parameter int unsigned MAX_BYTES  = bfiq_pkg::MaxBytesDef,
  parameter int unsigned NUM_PROBES = bfiq_pkg::NumProbesDef,
  localparam int unsigned IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
  localparam int unsigned SPAN_W = IDX_W + 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire bfiq_pkg::job_t     job_i,
  input  wire logic [SPAN_W-1:0]  span_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic                    maybe_present_o,
  output bfiq_pkg::back_stat_t    stat_o
);

  localparam int unsigned J_W     = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;
  localparam int unsigned SQ_W    = J_W + 2;
  localparam int unsigned STEPS   = bfiq_pkg::HashW / bfiq_pkg::DivBits;
  localparam int unsigned CNT_W   = $clog2(STEPS);
  localparam logic [J_W-1:0]   JLast   = J_W'(NUM_PROBES - 1);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(STEPS - 1);
  localparam logic [IDX_W-1:0] IxLast  = IDX_W'(MAX_BYTES - 1);

  localparam logic [2:0] BClr   = 3'd0;
  localparam logic [2:0] BIdle  = 3'd1;
  localparam logic [2:0] BDiv   = 3'd2;
  localparam logic [2:0] BRead  = 3'd3;
  localparam logic [2:0] BCheck = 3'd4;

  logic [2:0]        state_q;
  logic [IDX_W-1:0]  clr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [J_W-1:0]    j_q;
  logic [SQ_W-1:0]   sq_q;
  logic [63:0]       acc_q, div_q, hb_q;
  logic [SPAN_W-1:0] rem_q;
  logic              query_q;
  logic              done_q, maybe_q;

  logic [7:0]        mem_q [MAX_BYTES];
  logic [7:0]        rd_q;

  logic [SPAN_W-1:0] rem_d;
  logic [63:0]       div_d;
  logic [63:0]       acc_d;
  logic              bit_set;
  logic [7:0]        mask;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wix;
  logic [7:0]        mem_wdata;
  logic [IDX_W-1:0]  byte_ix;

  // Restoring reduction modulo the bit span, DivBits hash bits per step
  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    for (int k = 0; k < int'(bfiq_pkg::DivBits); k++) begin
      rem_d = {rem_d[SPAN_W-2:0], div_d[63]};
      div_d = div_d << 1;
      if (rem_d >= span_i) rem_d = rem_d - span_i;
    end
  end

  // Next probe address: add hb and the odd step of j*j
  assign acc_d = acc_q + hb_q + {{(64-SQ_W){1'b0}}, sq_q};

  assign byte_ix = rem_q[IDX_W+2:3];
  assign mask    = 8'd1 << rem_q[2:0];
  assign bit_set = (rd_q & mask) != 8'd0;

  // Write port: clearing pass or insert
  always_comb begin
    mem_we    = 1'b0;
    mem_wix   = byte_ix;
    mem_wdata = rd_q | mask;
    if (state_q == BClr) begin
      mem_we    = 1'b1;
      mem_wix   = clr_q;
      mem_wdata = 8'd0;
    end else if (state_q == BCheck && !query_q) begin
      mem_we = 1'b1;
    end
  end

  // Filter memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wix] <= mem_wdata;
    if (state_q == BRead) rd_q <= mem_q[byte_ix];
  end

  // Probe sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BClr;
      clr_q   <= '0;
      cnt_q   <= '0;
      j_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        BClr: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == IxLast) state_q <= BIdle;
        end
        BIdle: begin
          if (valid_i) begin
            cnt_q   <= '0;
            j_q     <= '0;
            state_q <= BDiv;
          end
        end
        BDiv: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CntLast) state_q <= BRead;
        end
        BRead: state_q <= BCheck;
        BCheck: begin
          if (query_q && !bit_set) begin
            done_q  <= 1'b1;
            state_q <= BIdle;
          end else if (j_q == JLast) begin
            done_q  <= query_q;
            state_q <= BIdle;
          end else begin
            j_q     <= j_q + J_W'(1);
            cnt_q   <= '0;
            state_q <= BDiv;
          end
        end
        default: state_q <= BIdle;
      endcase
    end
  end

  // Probe payload
  always_ff @(posedge clk_i) begin
    if (state_q == BIdle && valid_i) begin
      acc_q   <= job_i.ha;
      div_q   <= job_i.ha;
      hb_q    <= job_i.hb;
      query_q <= (job_i.mode == bfiq_pkg::ModeQuery);
      sq_q    <= SQ_W'(1);
      rem_q   <= '0;
    end
    if (state_q == BDiv) begin
      rem_q <= rem_d;
      div_q <= div_d;
    end
    if (state_q == BCheck) begin
      maybe_q <= bit_set;
      acc_q   <= acc_d;
      div_q   <= acc_d;
      sq_q    <= sq_q + SQ_W'(2);
      rem_q   <= '0;
    end
  end

  assign pop_o           = (state_q == BIdle) && valid_i;
  assign done_o          = done_q;
  assign maybe_present_o = maybe_q;
  assign stat_o.clearing = (state_q == BClr);
  assign stat_o.probing  = (state_q == BCheck);

endmodule
`default_nettype wire
